// ----- hdl/aesenc_pkg.sv -----
package aesenc_pkg;

    localparam int ROUND_COUNT_DEFAULT = 10;
    localparam int BLOCK_W = 128;
    localparam int HALF_W = 64;
    localparam int CFG_INDEX_W = 3;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] REG_CHAIN_MODE = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_KEY_HIGH   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_KEY_LOW    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_IV_HIGH    = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_IV_LOW     = 3'd4;

    localparam int RCON_DEPTH = 10;

    localparam logic [7:0] RCON [RCON_DEPTH] = '{
        8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1b, 8'h36
    };

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    function automatic logic [7:0] xtime(input logic [7:0] x);
        return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    // Byte n sits at bits 127-8n down; column n/4, row n%4.
    function automatic logic [BLOCK_W-1:0] sub_shift(input logic [BLOCK_W-1:0] s);
        logic [BLOCK_W-1:0] t;
        t = '0;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                t[BLOCK_W-1-8*(4*c+r) -: 8] =
                    SBOX[s[BLOCK_W-1-8*(4*((c+r)&3)+r) -: 8]];
            end
        end
        return t;
    endfunction

    function automatic logic [BLOCK_W-1:0] mix_columns(input logic [BLOCK_W-1:0] s);
        logic [BLOCK_W-1:0] t;
        logic [7:0] a0, a1, a2, a3, all;
        t = '0;
        for (int c = 0; c < 4; c++) begin
            a0 = s[BLOCK_W-1-32*c -: 8];
            a1 = s[BLOCK_W-9-32*c -: 8];
            a2 = s[BLOCK_W-17-32*c -: 8];
            a3 = s[BLOCK_W-25-32*c -: 8];
            all = a0 ^ a1 ^ a2 ^ a3;
            t[BLOCK_W-1-32*c -: 8]  = a0 ^ all ^ xtime(a0 ^ a1);
            t[BLOCK_W-9-32*c -: 8]  = a1 ^ all ^ xtime(a1 ^ a2);
            t[BLOCK_W-17-32*c -: 8] = a2 ^ all ^ xtime(a2 ^ a3);
            t[BLOCK_W-25-32*c -: 8] = a3 ^ all ^ xtime(a3 ^ a0);
        end
        return t;
    endfunction

    // One step of the AES-128 key schedule.
    function automatic logic [BLOCK_W-1:0] next_round_key(input logic [BLOCK_W-1:0] k,
                                                          input logic [7:0] rc);
        logic [31:0] w0, w1, w2, w3, rot, sub;
        w0 = k[127:96];
        w1 = k[95:64];
        w2 = k[63:32];
        w3 = k[31:0];
        rot = {w3[23:0], w3[31:24]};
        sub = {SBOX[rot[31:24]], SBOX[rot[23:16]], SBOX[rot[15:8]], SBOX[rot[7:0]]};
        w0 = w0 ^ sub ^ {rc, 24'h000000};
        w1 = w1 ^ w0;
        w2 = w2 ^ w1;
        w3 = w3 ^ w2;
        return {w0, w1, w2, w3};
    endfunction

endpackage

// ----- hdl/aesenc_ram.sv -----
module aesenc_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 11
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ----- hdl/aes128_block_encryptor.sv -----
// AES-128 encryptor for 128-bit words, in electronic codebook or cipher block
// chaining mode. Writing key_high or key_low starts a key expansion that stores
// the eleven round keys in two 64-bit round-key memories, one entry per cycle;
// while the expansion runs the input is not ready. The chaining value is
// applied as the word is accepted, and the word then passes through the single
// round unit (the initial key add and ten rounds), paced by one round-key read
// per cycle from the memories. The next word can be accepted only once the
// current one is through; one word is in flight at a time, since each block
// chains from the previous ciphertext. The result waits in an output register,
// so the next word can be accepted while the last result is still unclaimed;
// if it is still unclaimed when the next word reaches its last round, that
// round waits until it is taken.
// Byte 0 of every 128-bit quantity is bits 63:56 of its high half. Encrypting
// before any key was written gives undefined ciphertext.
module aes128_block_encryptor #(
    parameter int ROUND_COUNT = aesenc_pkg::ROUND_COUNT_DEFAULT
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_wr_en,
    input  logic [aesenc_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [aesenc_pkg::HALF_W-1:0]        cfg_wdata,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [aesenc_pkg::HALF_W-1:0]        s_data_high,
    input  logic [aesenc_pkg::HALF_W-1:0]        s_data_low,
    input  logic                                 s_first_block,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [aesenc_pkg::HALF_W-1:0]        m_cipher_high,
    output logic [aesenc_pkg::HALF_W-1:0]        m_cipher_low
);
    import aesenc_pkg::*;

    localparam int KEY_DEPTH = ROUND_COUNT + 1;
    localparam int RW = $clog2(KEY_DEPTH);
    localparam logic [RW-1:0] LAST = RW'(ROUND_COUNT);

    // Configuration registers.
    logic                chain_mode_reg;
    logic [HALF_W-1:0]   key_high_reg, key_low_reg, iv_high_reg, iv_low_reg;

    // Key expansion sequencer.
    logic                kexp_busy_reg;
    logic [RW-1:0]       kexp_cnt_reg;
    logic [BLOCK_W-1:0]  kexp_key_reg;
    logic [BLOCK_W-1:0]  kexp_key_next;
    logic [7:0]          kexp_rcon;

    // Encryption datapath.
    logic                busy_reg;
    logic [RW-1:0]       round_reg;
    logic [BLOCK_W-1:0]  state_reg;
    logic [BLOCK_W-1:0]  state_next;
    logic [BLOCK_W-1:0]  shifted;
    logic [BLOCK_W-1:0]  pre_key;
    logic [HALF_W-1:0]   chain_high_reg, chain_low_reg;
    logic                out_valid_reg;
    logic [HALF_W-1:0]   cipher_high_reg, cipher_low_reg;

    logic [RW-1:0]       rk_addr;
    logic [HALF_W-1:0]   rk_high, rk_low;

    logic                accept;
    logic                done;
    logic                key_wr;
    logic [BLOCK_W-1:0]  new_key;
    logic [BLOCK_W-1:0]  in_block;

    // The key memories take one full round key per cycle, high and low halves
    // side by side.
    aesenc_ram #(
        .WIDTH (HALF_W),
        .DEPTH (KEY_DEPTH)
    ) u_rk_high_ram (
        .aclk    (aclk),
        .wr_en   (kexp_busy_reg),
        .wr_addr (kexp_cnt_reg),
        .wr_data (kexp_key_reg[BLOCK_W-1:HALF_W]),
        .rd_addr (rk_addr),
        .rd_data (rk_high)
    );

    aesenc_ram #(
        .WIDTH (HALF_W),
        .DEPTH (KEY_DEPTH)
    ) u_rk_low_ram (
        .aclk    (aclk),
        .wr_en   (kexp_busy_reg),
        .wr_addr (kexp_cnt_reg),
        .wr_data (kexp_key_reg[HALF_W-1:0]),
        .rd_addr (rk_addr),
        .rd_data (rk_low)
    );

    assign s_ready = !busy_reg && !kexp_busy_reg;
    assign accept  = s_valid && s_ready;

    // The last round finishes only when the output register is free, so it holds
    // its key read and state until the previous word's result is taken.
    assign done = busy_reg && (round_reg == LAST) && (!out_valid_reg || m_ready);

    // The key for round r is read in the cycle before the round that uses it.
    always_comb begin
        if (accept) begin
            rk_addr = '0;
        end else if (round_reg == LAST) begin
            rk_addr = LAST;
        end else begin
            rk_addr = round_reg + RW'(1);
        end
    end

    assign key_wr  = cfg_wr_en && (cfg_index == REG_KEY_HIGH || cfg_index == REG_KEY_LOW);
    assign new_key = (cfg_index == REG_KEY_HIGH) ? {cfg_wdata, key_low_reg}
                                                 : {key_high_reg, cfg_wdata};

    assign kexp_rcon     = (kexp_cnt_reg == LAST) ? 8'h00 : RCON[kexp_cnt_reg];
    assign kexp_key_next = next_round_key(kexp_key_reg, kexp_rcon);

    // Chaining: the first block of a message uses the IV, others the last
    // ciphertext (including ciphertext produced in codebook mode).
    always_comb begin
        in_block = {s_data_high, s_data_low};
        if (chain_mode_reg) begin
            if (s_first_block) begin
                in_block = in_block ^ {iv_high_reg, iv_low_reg};
            end else begin
                in_block = in_block ^ {chain_high_reg, chain_low_reg};
            end
        end
    end

    // Round 0 is the bare key add, the last round skips the column mix.
    always_comb begin
        shifted = sub_shift(state_reg);
        if (round_reg == '0) begin
            pre_key = state_reg;
        end else if (round_reg == LAST) begin
            pre_key = shifted;
        end else begin
            pre_key = mix_columns(shifted);
        end
        state_next = pre_key ^ {rk_high, rk_low};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            chain_mode_reg  <= 1'b0;
            key_high_reg    <= '0;
            key_low_reg     <= '0;
            iv_high_reg     <= '0;
            iv_low_reg      <= '0;
            kexp_busy_reg   <= 1'b0;
            kexp_cnt_reg    <= '0;
            busy_reg        <= 1'b0;
            round_reg       <= '0;
            chain_high_reg  <= '0;
            chain_low_reg   <= '0;
            out_valid_reg   <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_CHAIN_MODE: chain_mode_reg <= cfg_wdata[0];
                    REG_KEY_HIGH:   key_high_reg   <= cfg_wdata;
                    REG_KEY_LOW:    key_low_reg    <= cfg_wdata;
                    REG_IV_HIGH:    iv_high_reg    <= cfg_wdata;
                    REG_IV_LOW:     iv_low_reg     <= cfg_wdata;
                    default: ;
                endcase
            end

            // A key write restarts the expansion from the updated key.
            if (key_wr) begin
                kexp_busy_reg <= 1'b1;
                kexp_cnt_reg  <= '0;
                kexp_key_reg  <= new_key;
            end else if (kexp_busy_reg) begin
                kexp_key_reg <= kexp_key_next;
                if (kexp_cnt_reg == LAST) begin
                    kexp_busy_reg <= 1'b0;
                end else begin
                    kexp_cnt_reg <= kexp_cnt_reg + RW'(1);
                end
            end

            if (accept) begin
                busy_reg  <= 1'b1;
                round_reg <= '0;
                state_reg <= in_block;
            end else if (done) begin
                busy_reg        <= 1'b0;
                chain_high_reg  <= state_next[BLOCK_W-1:HALF_W];
                chain_low_reg   <= state_next[HALF_W-1:0];
                cipher_high_reg <= state_next[BLOCK_W-1:HALF_W];
                cipher_low_reg  <= state_next[HALF_W-1:0];
            end else if (busy_reg && round_reg != LAST) begin
                state_reg <= state_next;
                round_reg <= round_reg + RW'(1);
            end

            if (done) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_cipher_high = cipher_high_reg;
    assign m_cipher_low  = cipher_low_reg;

endmodule
